// ===== rtl/hga_pkg.sv =====
// Shared types, widths and arithmetic helpers of the Hadamard Gram accumulator.
// No dependencies; every other file of the block imports this package.
package hga_pkg;

    localparam int DEFAULT_NUM_FACTORS = 4;
    localparam int IDX_PORT_W          = 3;
    localparam int Q_W                 = 16;
    localparam int RATING_W            = 4;
    localparam int SUM_W               = 48;
    localparam int PROD_W              = 2 * Q_W;
    localparam int WPROD_W             = Q_W + RATING_W + 1;

    localparam logic MODE_ACC      = 1'b0;
    localparam logic MODE_EMIT     = 1'b1;
    localparam logic KIND_GRAM     = 1'b0;
    localparam logic KIND_WEIGHTED = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Item handed from cell to cell.
    typedef struct packed {
        logic                    valid;
        logic [IDX_PORT_W-1:0]   index;
        logic signed [Q_W-1:0]   product;
        logic [RATING_W-1:0]     rating;
    } hga_token_t;

    // Signed 48-bit add with saturation.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    // Q8.24 to Q4.12: round half up, saturate to 16 bits.
    function automatic logic signed [Q_W-1:0] round_sat_q12(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0] biased;
        logic signed [PROD_W:0] shifted;
        biased  = {prod[PROD_W-1], prod} + (PROD_W+1)'(2048);
        shifted = biased >>> 12;
        if (shifted > (PROD_W+1)'(32767))
        begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
        if (shifted < -(PROD_W+1)'(32768))
        begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end
        return shifted[Q_W-1:0];
    endfunction

endpackage

// ===== rtl/hadamard_gram_accumulator.sv =====
// Top level of the Hadamard Gram accumulator: control, chain of cells, result port.
// Depends on hga_pkg, hga_product and hga_cell.
//
// Usage:
//   Input channel (item_valid/item_ready): mode 0 adds one element pair
//   (element_index k, b_value, c_value, rating); mode 1 asks for an emit run.
//   Elements of one tensor entry are sent with k rising from zero.
//   Accumulate items with k >= NUM_FACTORS are taken and dropped.
//   Result channel (result_valid/result_ready): an emit run gives
//   NUM_FACTORS*NUM_FACTORS Gram sums (kind 0, row-major), then NUM_FACTORS
//   weighted sums (kind 1, column 0); the final one carries last. The sums
//   are cleared once the final result is loaded into the output register.
// Timing:
//   An accumulate item holds the input until its token has cleared the chain:
//   product and rounding, then the token walks the chain one cell per cycle and
//   the last cell does its multiply and saturating add.
//   So no new item is taken while an accumulate item is still in flight.
//   An emit run issues one result per cycle while the receiver takes them; the
//   first result passes the state register, then the output register.
// Reset clears all sums and the control. A stalled receiver freezes the emit
// run; the result register holds its item until it is taken.
module hadamard_gram_accumulator #(
    parameter int NUM_FACTORS = hga_pkg::DEFAULT_NUM_FACTORS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            mode,
    input  logic [hga_pkg::IDX_PORT_W-1:0]  element_index,
    input  logic signed [hga_pkg::Q_W-1:0]  b_value,
    input  logic signed [hga_pkg::Q_W-1:0]  c_value,
    input  logic [hga_pkg::RATING_W-1:0]    rating,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            kind,
    output logic [hga_pkg::IDX_PORT_W-1:0]  row,
    output logic [hga_pkg::IDX_PORT_W-1:0]  column,
    output logic signed [hga_pkg::SUM_W-1:0] sum_value,
    output logic                            last
);
    import hga_pkg::*;

    localparam int IDX_W       = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
    localparam int BUSY_CYCLES = NUM_FACTORS + 3;
    localparam int BUSY_W      = $clog2(BUSY_CYCLES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FACTORS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [BUSY_W-1:0]      busy_reg;
    logic [BUSY_W-1:0]      busy_next;
    logic                   phase_reg;   // emit phase: Gram or weighted sums
    logic                   phase_next;
    logic [IDX_W-1:0]       r_reg;
    logic [IDX_W-1:0]       r_next;
    logic [IDX_W-1:0]       c_reg;
    logic [IDX_W-1:0]       c_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   kind_reg;
    logic [IDX_PORT_W-1:0]  row_reg;
    logic [IDX_PORT_W-1:0]  column_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                   last_reg;

    logic                   accept;
    logic                   launch;
    logic                   step;
    logic                   clear;
    logic [IDX_W-1:0]       lo;
    logic [IDX_W-1:0]       hi;

    hga_token_t                              link [NUM_FACTORS+1];
    logic [NUM_FACTORS-1:0][SUM_W-1:0]       gram_rows [NUM_FACTORS];
    logic [SUM_W-1:0]                        wsums [NUM_FACTORS];

    assign item_ready = (state_reg == ST_IDLE) && (busy_reg == '0);
    assign accept     = item_valid && item_ready;
    assign launch     = accept && (mode == MODE_ACC)
                        && ({1'b0, element_index} < (IDX_PORT_W+1)'(NUM_FACTORS));
    // one result leaves the sequencer whenever the output register frees up
    assign step       = (state_reg == ST_EMIT) && (!out_valid_reg || result_ready);
    assign clear      = step && phase_reg && (r_reg == LAST_IDX);

    // G is symmetric; only the upper triangle is accumulated
    assign lo = (r_reg <= c_reg) ? r_reg : c_reg;
    assign hi = (r_reg <= c_reg) ? c_reg : r_reg;

    hga_product u_product (
        .clk           (clk),
        .rst_n         (rst_n),
        .launch        (launch),
        .element_index (element_index),
        .b_value       (b_value),
        .c_value       (c_value),
        .rating        (rating),
        .tok_out       (link[0])
    );

    for (genvar i = 0; i < NUM_FACTORS; i++)
    begin : g_cell
        hga_cell #(
            .NUM_FACTORS (NUM_FACTORS),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (link[i]),
            .clear        (clear),
            .tok_out      (link[i+1]),
            .gram_row     (gram_rows[i]),
            .weighted_sum (wsums[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (busy_reg != '0)
        begin
            busy_next = busy_reg - 1'b1;
        end
        if (launch)
        begin
            busy_next = BUSY_W'(BUSY_CYCLES);
        end
        if (accept && (mode == MODE_EMIT))
        begin
            state_next = ST_EMIT;
            phase_next = KIND_GRAM;
            r_next     = '0;
            c_next     = '0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            if (phase_reg == KIND_GRAM)
            begin
                if (c_reg == LAST_IDX)
                begin
                    c_next = '0;
                    if (r_reg == LAST_IDX)
                    begin
                        r_next     = '0;
                        phase_next = KIND_WEIGHTED;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            else
            begin
                if (r_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            phase_reg     <= KIND_GRAM;
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg   <= phase_reg;
            row_reg    <= IDX_PORT_W'(r_reg);
            column_reg <= (phase_reg == KIND_GRAM) ? IDX_PORT_W'(c_reg) : '0;
            sum_reg    <= (phase_reg == KIND_GRAM) ? gram_rows[lo][hi] : wsums[r_reg];
            last_reg   <= phase_reg && (r_reg == LAST_IDX);
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign row          = row_reg;
    assign column       = column_reg;
    assign sum_value    = sum_reg;
    assign last         = last_reg;

    // Emit runs only start once the chain has drained.
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (busy_reg == '0))
        else $error("emit running while accumulation in flight");

    // A token leaving the chain is still covered by the busy window.
    a_token_covered: assert property (@(posedge clk) disable iff (!rst_n)
        link[NUM_FACTORS].valid |-> (busy_reg != '0))
        else $error("token outlived busy window");

    // Sums are cleared only on the final weighted result.
    a_clear_phase: assert property (@(posedge clk) disable iff (!rst_n)
        clear |-> (phase_reg == KIND_WEIGHTED) && (state_reg == ST_EMIT))
        else $error("sum clear outside weighted phase");

    // A stalled result holds its payload until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid
            && $stable({kind, row, column, sum_value, last}))
        else $error("result changed while stalled");

endmodule

// ===== rtl/hga_product.sv =====
// Front end: element product b*c, then rounding and saturation to Q4.12.
// Two register stages; emits a token for the head of the cell chain. Uses hga_pkg.
module hga_product (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          launch,
    input  logic [hga_pkg::IDX_PORT_W-1:0] element_index,
    input  logic signed [hga_pkg::Q_W-1:0] b_value,
    input  logic signed [hga_pkg::Q_W-1:0] c_value,
    input  logic [hga_pkg::RATING_W-1:0]  rating,
    output hga_pkg::hga_token_t           tok_out
);
    import hga_pkg::*;

    logic                       v1_reg;
    logic [IDX_PORT_W-1:0]      idx1_reg;
    logic [RATING_W-1:0]        rating1_reg;
    logic signed [PROD_W-1:0]   prod1_reg;
    logic signed [PROD_W-1:0]   prod1_next;
    logic                       v2_reg;
    logic [IDX_PORT_W-1:0]      idx2_reg;
    logic [RATING_W-1:0]        rating2_reg;
    logic signed [Q_W-1:0]      q2_reg;

    assign prod1_next = b_value * c_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= launch;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg    <= element_index;
        rating1_reg <= rating;
        prod1_reg   <= prod1_next;
        idx2_reg    <= idx1_reg;
        rating2_reg <= rating1_reg;
        q2_reg      <= round_sat_q12(prod1_reg);
    end

    assign tok_out = '{valid:   v2_reg,
                       index:   idx2_reg,
                       product: q2_reg,
                       rating:  rating2_reg};

endmodule

// ===== rtl/hga_cell.sv =====
// One cell of the chain: product p[m], Gram row m (upper triangle used) and R[m].
// Passes the token on each cycle; multiply stage then saturating add. Uses hga_pkg.
module hga_cell #(
    parameter int NUM_FACTORS = hga_pkg::DEFAULT_NUM_FACTORS,
    parameter int CELL_INDEX  = 0
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  hga_pkg::hga_token_t                         tok_in,
    input  logic                                        clear,
    output hga_pkg::hga_token_t                         tok_out,
    output logic [NUM_FACTORS-1:0][hga_pkg::SUM_W-1:0]  gram_row,
    output logic [hga_pkg::SUM_W-1:0]                   weighted_sum
);
    import hga_pkg::*;

    localparam int COL_W = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
    localparam logic [IDX_PORT_W-1:0] MY_IDX = IDX_PORT_W'(CELL_INDEX);

    logic                       fwd_valid_reg;
    logic [IDX_PORT_W-1:0]      fwd_index_reg;
    logic signed [Q_W-1:0]      fwd_product_reg;
    logic [RATING_W-1:0]        fwd_rating_reg;
    logic signed [Q_W-1:0]      p_reg;
    logic signed [Q_W-1:0]      partner;
    logic signed [PROD_W-1:0]   mul_reg;
    logic signed [PROD_W-1:0]   mul_next;
    logic signed [WPROD_W-1:0]  wmul_reg;
    logic signed [WPROD_W-1:0]  wmul_next;
    logic [COL_W-1:0]           col_reg;
    logic                       gupd_reg;
    logic                       wupd_reg;
    logic                       hit;
    logic                       upd;
    logic signed [SUM_W-1:0]    gram_reg [NUM_FACTORS];
    logic signed [SUM_W-1:0]    wsum_reg;

    assign hit       = tok_in.valid && (tok_in.index == MY_IDX);
    assign upd       = tok_in.valid && (tok_in.index >= MY_IDX);
    // the diagonal term pairs the new product with itself
    assign partner   = hit ? tok_in.product : p_reg;
    assign mul_next  = tok_in.product * partner;
    assign wmul_next = tok_in.product * $signed({1'b0, tok_in.rating});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            gupd_reg      <= 1'b0;
            wupd_reg      <= 1'b0;
            wsum_reg      <= '0;
            for (int j = 0; j < NUM_FACTORS; j++)
            begin
                gram_reg[j] <= '0;
            end
        end
        else
        begin
            fwd_valid_reg <= tok_in.valid;
            gupd_reg      <= upd;
            wupd_reg      <= hit;
            if (clear)
            begin
                wsum_reg <= '0;
                for (int j = 0; j < NUM_FACTORS; j++)
                begin
                    gram_reg[j] <= '0;
                end
            end
            else
            begin
                if (gupd_reg)
                begin
                    gram_reg[col_reg] <= sat_add(gram_reg[col_reg],
                        {{(SUM_W-PROD_W){mul_reg[PROD_W-1]}}, mul_reg});
                end
                if (wupd_reg)
                begin
                    wsum_reg <= sat_add(wsum_reg,
                        {{(SUM_W-WPROD_W){wmul_reg[WPROD_W-1]}}, wmul_reg});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_index_reg   <= tok_in.index;
        fwd_product_reg <= tok_in.product;
        fwd_rating_reg  <= tok_in.rating;
        mul_reg         <= mul_next;
        wmul_reg        <= wmul_next;
        col_reg         <= tok_in.index[COL_W-1:0];
        if (hit)
        begin
            p_reg <= tok_in.product;
        end
    end

    assign tok_out      = '{valid:   fwd_valid_reg,
                            index:   fwd_index_reg,
                            product: fwd_product_reg,
                            rating:  fwd_rating_reg};
    assign weighted_sum = wsum_reg;

    always_comb
    begin
        for (int j = 0; j < NUM_FACTORS; j++)
        begin
            gram_row[j] = gram_reg[j];
        end
    end

endmodule

// ===== sim/tb_hadamard_gram_accumulator.sv =====
// Testbench for hadamard_gram_accumulator: checks Gram and weighted-sum emit runs
// against a cycle-free predictor of the sums. Depends on hga_pkg and the RTL top.
module tb_hadamard_gram_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    import hga_pkg::*;

    localparam int     NF          = DEFAULT_NUM_FACTORS;
    localparam int     RUN_LEN     = NF * NF + NF;   // results per emit run
    localparam int     STUCK_LIMIT = 3000;           // cycles with no handshake
    localparam int     HOLD_CYCLES = 300;            // long receiver hold-off
    localparam int     HOLD_AFTER  = 200;            // results seen before hold-off
    localparam int     RANDOM_ITEMS = 290;
    localparam longint SUM_HI      = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO      = -(longint'(1) <<< (SUM_W - 1));

    // One input item as offered on the input channel.
    typedef struct packed {
        logic                  mode;
        logic [IDX_PORT_W-1:0] idx;
        logic signed [Q_W-1:0] b;
        logic signed [Q_W-1:0] c;
        logic [RATING_W-1:0]   rating;
    } pair_item_t;

    // One emitted sum as seen on the result channel.
    typedef struct packed {
        logic                    kind;
        logic [IDX_PORT_W-1:0]   row;
        logic [IDX_PORT_W-1:0]   column;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } sum_result_t;

    // Clock, reset and DUT ports; all inputs start at a known value.
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    item_valid    = 1'b0;
    logic                    item_ready;
    logic                    mode          = MODE_ACC;
    logic [IDX_PORT_W-1:0]   element_index = '0;
    logic signed [Q_W-1:0]   b_value       = '0;
    logic signed [Q_W-1:0]   c_value       = '0;
    logic [RATING_W-1:0]     rating        = '0;
    logic                    result_valid;
    logic                    result_ready  = 1'b0;
    logic                    kind;
    logic [IDX_PORT_W-1:0]   row;
    logic [IDX_PORT_W-1:0]   column;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last;

    // Stimulus and scoreboard state.
    pair_item_t  pending_items[$];
    sum_result_t expected_sums[$];
    pair_item_t  offered_item;
    sum_result_t seen_result;
    int          error_count  = 0;
    int          results_seen = 0;
    int          cyc          = 0;
    int          stuck        = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        quiet;
    int          random_count;
    int          choice;
    logic [RATING_W-1:0] entry_rating;

    // Predictor state: stored products and the running sums.
    logic signed [Q_W-1:0] product_row[NF];
    longint                gram_acc[NF][NF];
    longint                weighted_acc[NF];

    hadamard_gram_accumulator #(
        .NUM_FACTORS (NF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .mode          (mode),
        .element_index (element_index),
        .b_value       (b_value),
        .c_value       (c_value),
        .rating        (rating),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .kind          (kind),
        .row           (row),
        .column        (column),
        .sum_value     (sum_value),
        .last          (last)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // No random idling on either side inside this window of cycles.
    assign quiet = (cyc >= 1200) && (cyc < 2000);

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // b*c is exact in Q8.24; round half up to Q4.12 and clamp to 16 bits.
    function automatic logic signed [Q_W-1:0] q12_product(
        input logic signed [Q_W-1:0] b,
        input logic signed [Q_W-1:0] c
    );
        longint exact;
        longint rounded;
        exact   = longint'(b) * longint'(c);
        rounded = (exact + 2048) >>> 12;
        if (rounded > 32767)
        begin
            rounded = 32767;
        end
        else if (rounded < -32768)
        begin
            rounded = -32768;
        end
        return rounded[Q_W-1:0];
    endfunction

    // Sums clamp at the signed 48-bit range on every add.
    function automatic longint sum_clamped(input longint acc, input longint term);
        longint s;
        s = acc + term;
        if (s > SUM_HI)
        begin
            return SUM_HI;
        end
        if (s < SUM_LO)
        begin
            return SUM_LO;
        end
        return s;
    endfunction

    // Applies one accepted item to the sums; an emit queues the whole run.
    task automatic update_gram_sums(input pair_item_t it);
        logic signed [Q_W-1:0] p;
        longint                term;
        sum_result_t           r;
        int                    n;
        if (it.mode == MODE_ACC)
        begin
            if (it.idx < NF)
            begin
                p = q12_product(it.b, it.c);
                product_row[it.idx] = p;
                // partners below k come from whatever the row holds, stale or not
                for (int m = 0; m < it.idx; m++)
                begin
                    term = longint'(p) * longint'(product_row[m]);
                    gram_acc[it.idx][m] = sum_clamped(gram_acc[it.idx][m], term);
                    gram_acc[m][it.idx] = sum_clamped(gram_acc[m][it.idx], term);
                end
                gram_acc[it.idx][it.idx] = sum_clamped(gram_acc[it.idx][it.idx],
                                                       longint'(p) * longint'(p));
                weighted_acc[it.idx] = sum_clamped(weighted_acc[it.idx],
                                                   longint'(p) * longint'(it.rating));
            end
        end
        else
        begin
            n = 0;
            for (int i = 0; i < NF; i++)
            begin
                for (int j = 0; j < NF; j++)
                begin
                    r.kind   = KIND_GRAM;
                    r.row    = IDX_PORT_W'(i);
                    r.column = IDX_PORT_W'(j);
                    r.sum    = gram_acc[i][j][SUM_W-1:0];
                    r.last   = (n == RUN_LEN - 1);
                    expected_sums.push_back(r);
                    gram_acc[i][j] = 0;
                    n++;
                end
            end
            for (int i = 0; i < NF; i++)
            begin
                r.kind   = KIND_WEIGHTED;
                r.row    = IDX_PORT_W'(i);
                r.column = '0;
                r.sum    = weighted_acc[i][SUM_W-1:0];
                r.last   = (n == RUN_LEN - 1);
                expected_sums.push_back(r);
                weighted_acc[i] = 0;
                n++;
            end
        end
    endtask

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    task automatic add_item(
        input logic                  md,
        input logic [IDX_PORT_W-1:0] k,
        input logic signed [Q_W-1:0] b,
        input logic signed [Q_W-1:0] c,
        input logic [RATING_W-1:0]   rt
    );
        pair_item_t it;
        it.mode   = md;
        it.idx    = k;
        it.b      = b;
        it.c      = c;
        it.rating = rt;
        pending_items.push_back(it);
    endtask

    // Emit items carry random junk in the ignored fields.
    task automatic add_emit();
        add_item(MODE_EMIT, IDX_PORT_W'($urandom), Q_W'($urandom), Q_W'($urandom),
                 RATING_W'($urandom));
    endtask

    // Mix of full-range values, small values and the extremes.
    function automatic logic signed [Q_W-1:0] pick_q12();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            return Q_W'($urandom);
        end
        if (sel < 80)
        begin
            return Q_W'($urandom_range(8192) - 4096);
        end
        unique case ($urandom_range(4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Ratings above ten show up now and then.
    function automatic logic [RATING_W-1:0] pick_rating();
        if ($urandom_range(99) < 85)
        begin
            return RATING_W'($urandom_range(10));
        end
        return RATING_W'($urandom_range(15, 11));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_valid || expected_sums.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    //------------------------------------------------------------------
    // Driver: offers pending items; predicts each one when it is taken
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid    <= 1'b0;
            mode          <= MODE_ACC;
            element_index <= '0;
            b_value       <= '0;
            c_value       <= '0;
            rating        <= '0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                update_gram_sums(offered_item);
            end
            // a new item only once the current one is gone
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 9))
                begin
                    offered_item = pending_items.pop_front();
                    mode          <= offered_item.mode;
                    element_index <= offered_item.idx;
                    b_value       <= offered_item.b;
                    c_value       <= offered_item.c;
                    rating        <= offered_item.rating;
                    item_valid    <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off that backs up the block
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    //------------------------------------------------------------------
    // Monitor: each taken result against the oldest expectation
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            seen_result.kind   = kind;
            seen_result.row    = row;
            seen_result.column = column;
            seen_result.sum    = sum_value;
            seen_result.last   = last;
            results_seen <= results_seen + 1;
            if (expected_sums.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("unexpected result: kind %0d row %0d col %0d sum %0d last %0d",
                             kind, row, column, sum_value, last);
                end
            end
            else if (seen_result.kind !== expected_sums[0].kind
                     || seen_result.row !== expected_sums[0].row
                     || seen_result.column !== expected_sums[0].column
                     || seen_result.sum !== expected_sums[0].sum
                     || seen_result.last !== expected_sums[0].last)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("mismatch: exp kind %0d row %0d col %0d sum %0d last %0d",
                             expected_sums[0].kind, expected_sums[0].row,
                             expected_sums[0].column, expected_sums[0].sum,
                             expected_sums[0].last);
                    $display("          got kind %0d row %0d col %0d sum %0d last %0d",
                             kind, row, column, sum_value, last);
                end
                void'(expected_sums.pop_front());
            end
            else
            begin
                void'(expected_sums.pop_front());
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog: counts cycles with work outstanding but no handshake
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (pending_items.size() == 0 && !item_valid && expected_sums.size() == 0))
        begin
            stuck <= 0;
        end
        else
        begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence: directed items, a full drain, random items, final check
    //------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NF; i++)
        begin
            product_row[i]  = '0;
            weighted_acc[i] = 0;
            for (int j = 0; j < NF; j++)
            begin
                gram_acc[i][j] = 0;
            end
        end

        // First entry writes every stored product: saturation both ways, zero.
        add_item(MODE_ACC, 3'd0, 16'sh7FFF, 16'sh7FFF, 4'd10);
        add_item(MODE_ACC, 3'd1, 16'sh8000, 16'sh7FFF, 4'd10);
        add_item(MODE_ACC, 3'd2, 16'sh8000, 16'sh8000, 4'd10);
        add_item(MODE_ACC, 3'd3, 16'sh0000, 16'sh8000, 4'd10);
        add_emit();
        // Rounding ties +0.5, -0.5, -1.5, +1.5; ratings above ten.
        add_item(MODE_ACC, 3'd0, 16'sd1, 16'sd2048, 4'd15);
        add_item(MODE_ACC, 3'd1, -16'sd1, 16'sd2048, 4'd15);
        add_item(MODE_ACC, 3'd2, -16'sd3, 16'sd2048, 4'd11);
        add_item(MODE_ACC, 3'd3, 16'sd3, 16'sd2048, 4'd11);
        // Out-of-range positions are dropped.
        add_item(MODE_ACC, 3'd4, 16'sh7FFF, 16'sh7FFF, 4'd9);
        add_item(MODE_ACC, 3'd7, 16'sh8000, 16'sh7FFF, 4'd15);
        // Out of order: partners are stale products.
        add_item(MODE_ACC, 3'd2, 16'sd4096, 16'sd4096, 4'd5);
        add_item(MODE_ACC, 3'd1, 16'sh7FFF, -16'sd4096, 4'd0);
        add_emit();
        // Partial entry, then emit twice in a row (second run all zero).
        add_item(MODE_ACC, 3'd0, -16'sd12345, 16'sd321, 4'd7);
        add_item(MODE_ACC, 3'd1, 16'sd9999, -16'sd8888, 4'd7);
        add_emit();
        add_emit();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sender pauses here until every expected result has come back.
        @(negedge clk);
        wait_drained();

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            choice = $urandom_range(99);
            if (choice < 70)
            begin
                // well-formed entry with one rating, often followed by an emit
                entry_rating = pick_rating();
                for (int k = 0; k < NF; k++)
                begin
                    add_item(MODE_ACC, IDX_PORT_W'(k), pick_q12(), pick_q12(), entry_rating);
                end
                random_count += NF;
                if ($urandom_range(99) < 30)
                begin
                    add_emit();
                    random_count++;
                end
            end
            else if (choice < 80)
            begin
                add_emit();
                random_count++;
            end
            else if (choice < 88)
            begin
                // out-of-range noise, ignored by the block
                add_item(MODE_ACC, IDX_PORT_W'($urandom_range(7, NF)), pick_q12(),
                         pick_q12(), RATING_W'($urandom));
                random_count++;
            end
            else
            begin
                // stray element out of sequence
                add_item(MODE_ACC, IDX_PORT_W'($urandom_range(NF - 1)), pick_q12(),
                         pick_q12(), pick_rating());
                random_count++;
            end
        end
        add_emit();

        wait_drained();
        repeat (NF + 10) @(negedge clk);

        if (error_count == 0 && expected_sums.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hga_pkg.sv
rtl/hga_product.sv
rtl/hga_cell.sv
rtl/hadamard_gram_accumulator.sv
sim/tb_hadamard_gram_accumulator.sv
